// File: src/rbpa_pkg.sv
// Shared constants, codes and inter-module control structs of the block pool allocator.
// Depends on nothing; every other file refers to it by scoped names.
package rbpa_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int POOL_DEPTH  = 4096;

	localparam int ADDR_W      = 64;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int CNT_FIELD_W = 5;
	localparam int OWN_W       = 4;
	localparam int SHIFT_W     = 5;
	localparam int BPS_W       = 13;

	localparam int SRV_W   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int SCNT_W  = $clog2(MAX_SERVERS + 1);
	localparam int IDX_W   = $clog2(POOL_DEPTH);
	localparam int FILL_W  = $clog2(POOL_DEPTH + 1);
	localparam int ROUND_W = $clog2(POOL_DEPTH * MAX_SERVERS + 1);
	localparam int PROD_W  = FILL_W + SCNT_W;
	localparam int LIM_W   = ROUND_W + 1 + CNT_FIELD_W;
	localparam int STEP_W  = $clog2(ROUND_W + 1);

	// reset values of the configuration registers
	localparam logic [CNT_FIELD_W-1:0] RST_SERVER_COUNT  = CNT_FIELD_W'(1);
	localparam logic [CNT_FIELD_W-1:0] RST_REPLICA_COUNT = CNT_FIELD_W'(1);
	localparam logic [OWN_W-1:0]       RST_OWN_ID        = '0;
	localparam logic [ADDR_W-1:0]      RST_KV_BASE       = '0;
	localparam logic [SHIFT_W-1:0]     RST_BLOCK_SHIFT   = SHIFT_W'(20);
	localparam logic [BPS_W-1:0]       RST_BPS           = '0;

	typedef enum logic [KIND_W-1:0] {
		KIND_PLAN  = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_FREE  = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_REJECT    = 3'd2,
		ST_DONE      = 3'd3,
		ST_EXHAUSTED = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERVER_COUNT  = 3'd0,
		REG_REPLICA_COUNT = 3'd1,
		REG_OWN_ID        = 3'd2,
		REG_KV_BASE       = 3'd3,
		REG_BLOCK_SHIFT   = 3'd4,
		REG_BPS           = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic               start;
		logic [ROUND_W-1:0] dividend;
		logic [SCNT_W-1:0]  divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [SRV_W-1:0] rem;
	} mod_rsp_t;

	typedef struct packed {
		logic             push;
		logic [IDX_W-1:0] push_idx;
		logic             pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic             rd;
		logic             we;
		logic             wbit;
		logic [IDX_W-1:0] addr;
	} mark_req_t;

endpackage

// File: src/rbpa_ifs.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on rbpa_pkg for field widths.
interface rbpa_req_if;
	logic                          valid;
	logic                          ready;
	logic [rbpa_pkg::KIND_W-1:0]   kind;
	logic [rbpa_pkg::ADDR_W-1:0]   free_address;

	modport source (output valid, kind, free_address, input ready);
	modport sink (input valid, kind, free_address, output ready);
endinterface

interface rbpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rbpa_pkg::ADDR_W-1:0]   block_address;
	logic                          pushed;
	logic [rbpa_pkg::STATUS_W-1:0] status;

	modport source (output valid, block_address, pushed, status, input ready);
	modport sink (input valid, block_address, pushed, status, output ready);
endinterface

// File: src/replicated_block_pool_allocator_top.sv
// Replicated block pool allocator: top level with the configuration registers and sequencer.
// Depends on rbpa_pkg, rbpa_ifs, rbpa_mod_unit, rbpa_free_fifo and rbpa_mark_mem.
//
// The block hands out fixed-size blocks (2^block_shift bytes) of this server's key-value
// area and takes them back. One request beat is worked on at a time and gives exactly one
// response beat; the request channel is not ready while a beat is in work, but a finished
// response waits in its own output register, so the next request is taken even while the
// consumer stalls. Alloc pops a block index from the free FIFO memory, a registered read,
// and sets the block's bit in the mark memory; free reads the block's mark bit, also a
// registered read, then clears it and requeues the block on the free FIFO. Once planning
// has finished, a plan step answers done without starting the remainder unit. The
// round start (round counter modulo server count) comes from a bit-serial remainder unit
// that takes one counter bit (of 17) per cycle, then the sequencer walks the per-server block
// counters one server per cycle, first to skip full servers, then to take one block on
// each replica, and on a full replica it walks back over the servers it already charged.
// After reset the mark memory is cleared one entry per cycle, all POOL_DEPTH (4096) entries,
// before the first request is accepted; configuration writes are taken during that time.
// Write configuration only while idle.
module replicated_block_pool_allocator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	rbpa_req_if.sink                            req,
	rbpa_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [rbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_P_CMP  = 13'b0000000000100,
		S_P_MOD  = 13'b0000000001000,
		S_P_SKIP = 13'b0000000010000,
		S_P_REP  = 13'b0000000100000,
		S_P_UNDO = 13'b0000001000000,
		S_P_OWN  = 13'b0000010000000,
		S_A_POP  = 13'b0000100000000,
		S_A_MARK = 13'b0001000000000,
		S_F_CHK  = 13'b0010000000000,
		S_F_MARK = 13'b0100000000000,
		S_FIN    = 13'b1000000000000
	} state_t;

	// configuration registers
	logic [rbpa_pkg::CNT_FIELD_W-1:0] server_count_q;
	logic [rbpa_pkg::CNT_FIELD_W-1:0] replica_count_q;
	logic [rbpa_pkg::OWN_W-1:0]       own_id_q;
	logic [rbpa_pkg::ADDR_W-1:0]      kv_base_q;
	logic [rbpa_pkg::SHIFT_W-1:0]     block_shift_q;
	logic [rbpa_pkg::BPS_W-1:0]       bps_q;

	// effective values of the count registers
	logic [rbpa_pkg::SCNT_W-1:0]      sc_eff;
	logic [rbpa_pkg::CNT_FIELD_W-1:0] rc_eff;
	logic [rbpa_pkg::FILL_W-1:0]      bps_eff;

	// sequencer state
	state_t                           state_q;
	logic [rbpa_pkg::ROUND_W-1:0]     round_q;
	logic [rbpa_pkg::FILL_W-1:0]      used_q [rbpa_pkg::MAX_SERVERS];
	logic [rbpa_pkg::SRV_W-1:0]       ptr_q;
	logic [rbpa_pkg::SRV_W-1:0]       st_q;
	logic [rbpa_pkg::SCNT_W-1:0]      tries_q;
	logic [rbpa_pkg::CNT_FIELD_W-1:0] i_q;
	logic [rbpa_pkg::IDX_W-1:0]       own_idx_q;
	logic [rbpa_pkg::PROD_W-1:0]      prod_q;
	logic [rbpa_pkg::LIM_W-1:0]       lim_q;
	logic [rbpa_pkg::ADDR_W-1:0]      off_q;
	logic                             neg_q;
	logic [rbpa_pkg::IDX_W-1:0]       fidx_q;

	// result of the beat in work
	logic [rbpa_pkg::IDX_W-1:0]       res_idx_q;
	logic                             res_addr_en_q;
	logic                             res_pushed_q;
	rbpa_pkg::status_t                res_status_q;

	// output register
	logic                             rsp_valid_q;
	logic [rbpa_pkg::ADDR_W-1:0]      rsp_addr_q;
	logic                             rsp_pushed_q;
	logic [rbpa_pkg::STATUS_W-1:0]    rsp_status_q;

	// datapath
	logic [rbpa_pkg::FILL_W-1:0]      used_rd;
	logic                             used_full;
	logic [rbpa_pkg::SRV_W-1:0]       sc_last;
	logic [rbpa_pkg::SRV_W-1:0]       ptr_next;
	logic [rbpa_pkg::SRV_W-1:0]       ptr_prev;
	logic                             plan_done;
	logic                             own_hit;
	logic [rbpa_pkg::ADDR_W-1:0]      shifted;
	logic [rbpa_pkg::ADDR_W-1:0]      align_mask;
	logic                             free_ok;
	logic [rbpa_pkg::IDX_W-1:0]       fidx_c;
	logic [rbpa_pkg::ADDR_W-1:0]      blk_addr;

	// submodule links
	rbpa_pkg::mod_req_t               mod_req;
	rbpa_pkg::mod_rsp_t               mod_rsp;
	rbpa_pkg::fifo_ctl_t              fifo_ctl;
	rbpa_pkg::fifo_stat_t             fifo_stat;
	logic [rbpa_pkg::IDX_W-1:0]       fifo_rd_idx;
	rbpa_pkg::mark_req_t              mark_req;
	logic                             mark_bit;
	logic                             mark_busy;

	rbpa_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	rbpa_free_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.stat   (fifo_stat),
		.rd_idx (fifo_rd_idx)
	);

	rbpa_mark_mem u_marks (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mark_req),
		.rd_bit (mark_bit),
		.busy   (mark_busy)
	);

	// Configuration writes; indexes past the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q  <= rbpa_pkg::RST_SERVER_COUNT;
			replica_count_q <= rbpa_pkg::RST_REPLICA_COUNT;
			own_id_q        <= rbpa_pkg::RST_OWN_ID;
			kv_base_q       <= rbpa_pkg::RST_KV_BASE;
			block_shift_q   <= rbpa_pkg::RST_BLOCK_SHIFT;
			bps_q           <= rbpa_pkg::RST_BPS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbpa_pkg::REG_SERVER_COUNT: begin
					server_count_q <= cfg_wdata[rbpa_pkg::CNT_FIELD_W-1:0];
				end
				rbpa_pkg::REG_REPLICA_COUNT: begin
					replica_count_q <= cfg_wdata[rbpa_pkg::CNT_FIELD_W-1:0];
				end
				rbpa_pkg::REG_OWN_ID: begin
					own_id_q <= cfg_wdata[rbpa_pkg::OWN_W-1:0];
				end
				rbpa_pkg::REG_KV_BASE: begin
					kv_base_q <= cfg_wdata[rbpa_pkg::ADDR_W-1:0];
				end
				rbpa_pkg::REG_BLOCK_SHIFT: begin
					block_shift_q <= cfg_wdata[rbpa_pkg::SHIFT_W-1:0];
				end
				rbpa_pkg::REG_BPS: begin
					bps_q <= cfg_wdata[rbpa_pkg::BPS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the counts: zero servers or replicas act as one, and the server count and the
	// blocks per server saturate at what the storage holds.
	always_comb begin
		if (server_count_q == '0) begin
			sc_eff = rbpa_pkg::SCNT_W'(1);
		end else if (32'(server_count_q) > rbpa_pkg::MAX_SERVERS) begin
			sc_eff = rbpa_pkg::SCNT_W'(rbpa_pkg::MAX_SERVERS);
		end else begin
			sc_eff = rbpa_pkg::SCNT_W'(server_count_q);
		end
	end

	assign rc_eff  = (replica_count_q == '0) ? rbpa_pkg::CNT_FIELD_W'(1) : replica_count_q;
	assign bps_eff = (32'(bps_q) > rbpa_pkg::POOL_DEPTH)
		? rbpa_pkg::FILL_W'(rbpa_pkg::POOL_DEPTH) : rbpa_pkg::FILL_W'(bps_q);

	// Server walk: one counter read per cycle at the walk pointer, wrapping at the
	// server count in both directions.
	assign used_rd   = used_q[ptr_q];
	assign used_full = (used_rd >= bps_eff);
	assign sc_last   = rbpa_pkg::SRV_W'(sc_eff - rbpa_pkg::SCNT_W'(1));
	assign ptr_next  = (ptr_q == sc_last) ? '0 : ptr_q + rbpa_pkg::SRV_W'(1);
	assign ptr_prev  = (ptr_q == '0) ? sc_last : ptr_q - rbpa_pkg::SRV_W'(1);

	// Planning is over once round_counter >= floor(blocks * servers / replicas), which is
	// the same as (round_counter + 1) * replicas > blocks * servers.
	assign plan_done = (lim_q > rbpa_pkg::LIM_W'(prod_q));
	assign own_hit   = (32'(st_q) == 32'(own_id_q));

	// Free address checks on the offset from the base: below the base, off a block
	// boundary, or a block index beyond the pool are all rejected.
	assign shifted    = off_q >> block_shift_q;
	assign align_mask = (rbpa_pkg::ADDR_W'(1) << block_shift_q) - rbpa_pkg::ADDR_W'(1);
	assign free_ok    = !neg_q && ((off_q & align_mask) == '0)
		&& (shifted < rbpa_pkg::ADDR_W'(rbpa_pkg::POOL_DEPTH));
	assign fidx_c     = shifted[rbpa_pkg::IDX_W-1:0];

	assign blk_addr = kv_base_q + (rbpa_pkg::ADDR_W'(res_idx_q) << block_shift_q);

	// Requests to the shared units follow the sequencer state.
	always_comb begin
		mod_req.start     = 1'b0;
		mod_req.dividend  = round_q;
		mod_req.divisor   = sc_eff;
		fifo_ctl.push     = 1'b0;
		fifo_ctl.push_idx = own_idx_q;
		fifo_ctl.pop      = 1'b0;
		mark_req.rd       = 1'b0;
		mark_req.we       = 1'b0;
		mark_req.wbit     = 1'b0;
		mark_req.addr     = fidx_q;
		unique case (state_q)
			S_P_CMP: begin
				mod_req.start = !plan_done;
			end
			S_P_OWN: begin
				fifo_ctl.push = own_hit;
			end
			S_A_POP: begin
				fifo_ctl.pop = !fifo_stat.empty;
			end
			S_A_MARK: begin
				mark_req.we   = 1'b1;
				mark_req.wbit = 1'b1;
				mark_req.addr = fifo_rd_idx;
			end
			S_F_CHK: begin
				mark_req.rd   = free_ok;
				mark_req.addr = fidx_c;
			end
			S_F_MARK: begin
				mark_req.we       = mark_bit;
				fifo_ctl.push     = mark_bit;
				fifo_ctl.push_idx = fidx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			round_q       <= '0;
			for (int k = 0; k < rbpa_pkg::MAX_SERVERS; k++) begin
				used_q[k] <= '0;
			end
			ptr_q         <= '0;
			st_q          <= '0;
			tries_q       <= '0;
			i_q           <= '0;
			own_idx_q     <= '0;
			prod_q        <= '0;
			lim_q         <= '0;
			off_q         <= '0;
			neg_q         <= 1'b0;
			fidx_q        <= '0;
			res_idx_q     <= '0;
			res_addr_en_q <= 1'b0;
			res_pushed_q  <= 1'b0;
			res_status_q  <= rbpa_pkg::ST_OK;
			rsp_valid_q   <= 1'b0;
			rsp_addr_q    <= '0;
			rsp_pushed_q  <= 1'b0;
			rsp_status_q  <= '0;
		end else begin
			// drop the response once the consumer takes the beat, unless a new one replaces it
			if (rsp_valid_q && rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					if (!mark_busy) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (req.valid) begin
						res_addr_en_q <= 1'b0;
						res_pushed_q  <= 1'b0;
						res_status_q  <= rbpa_pkg::ST_OK;
						// set up the planning limit and the free offset for every beat
						prod_q <= rbpa_pkg::PROD_W'(bps_eff) * rbpa_pkg::PROD_W'(sc_eff);
						lim_q  <= (rbpa_pkg::LIM_W'(round_q) + rbpa_pkg::LIM_W'(1))
							* rbpa_pkg::LIM_W'(rc_eff);
						off_q  <= req.free_address - kv_base_q;
						neg_q  <= (req.free_address < kv_base_q);
						unique case (req.kind)
							rbpa_pkg::KIND_PLAN:  state_q <= S_P_CMP;
							rbpa_pkg::KIND_ALLOC: state_q <= S_A_POP;
							rbpa_pkg::KIND_FREE:  state_q <= S_F_CHK;
							default:              state_q <= S_FIN;
						endcase
					end
				end

				S_P_CMP: begin
					if (plan_done) begin
						res_status_q <= rbpa_pkg::ST_DONE;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_P_MOD;
					end
				end

				S_P_MOD: begin
					if (mod_rsp.done) begin
						ptr_q   <= mod_rsp.rem;
						tries_q <= '0;
						state_q <= S_P_SKIP;
					end
				end

				// skip full servers, at most one lap
				S_P_SKIP: begin
					if (!used_full) begin
						st_q      <= ptr_q;
						own_idx_q <= used_rd[rbpa_pkg::IDX_W-1:0];
						i_q       <= '0;
						state_q   <= S_P_REP;
					end else if (tries_q == sc_eff - rbpa_pkg::SCNT_W'(1)) begin
						res_status_q <= rbpa_pkg::ST_EXHAUSTED;
						state_q      <= S_FIN;
					end else begin
						tries_q <= tries_q + rbpa_pkg::SCNT_W'(1);
						ptr_q   <= ptr_next;
					end
				end

				// charge one block on each replica server in turn
				S_P_REP: begin
					if (i_q == rc_eff) begin
						state_q <= S_P_OWN;
					end else if (used_full) begin
						if (i_q == '0) begin
							res_status_q <= rbpa_pkg::ST_EXHAUSTED;
							state_q      <= S_FIN;
						end else begin
							ptr_q   <= ptr_prev;
							state_q <= S_P_UNDO;
						end
					end else begin
						used_q[ptr_q] <= used_rd + rbpa_pkg::FILL_W'(1);
						ptr_q         <= ptr_next;
						i_q           <= i_q + rbpa_pkg::CNT_FIELD_W'(1);
					end
				end

				// a replica hit a full server: take back every block charged so far
				S_P_UNDO: begin
					used_q[ptr_q] <= used_rd - rbpa_pkg::FILL_W'(1);
					ptr_q         <= ptr_prev;
					i_q           <= i_q - rbpa_pkg::CNT_FIELD_W'(1);
					if (i_q == rbpa_pkg::CNT_FIELD_W'(1)) begin
						res_status_q <= rbpa_pkg::ST_EXHAUSTED;
						state_q      <= S_FIN;
					end
				end

				S_P_OWN: begin
					round_q <= round_q + rbpa_pkg::ROUND_W'(1);
					if (own_hit) begin
						res_idx_q     <= own_idx_q;
						res_addr_en_q <= 1'b1;
						res_pushed_q  <= !fifo_stat.full;
					end
					state_q <= S_FIN;
				end

				S_A_POP: begin
					if (fifo_stat.empty) begin
						res_status_q <= rbpa_pkg::ST_EMPTY;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_A_MARK;
					end
				end

				S_A_MARK: begin
					res_idx_q     <= fifo_rd_idx;
					res_addr_en_q <= 1'b1;
					state_q       <= S_FIN;
				end

				S_F_CHK: begin
					if (!free_ok) begin
						res_status_q <= rbpa_pkg::ST_REJECT;
						state_q      <= S_FIN;
					end else begin
						fidx_q  <= fidx_c;
						state_q <= S_F_MARK;
					end
				end

				// an unmarked block is rejected; a marked one is cleared and requeued
				S_F_MARK: begin
					if (!mark_bit) begin
						res_status_q <= rbpa_pkg::ST_REJECT;
					end
					state_q <= S_FIN;
				end

				// hold the result until the output register is free
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_addr_q   <= res_addr_en_q ? blk_addr : '0;
						rsp_pushed_q <= res_pushed_q;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.pushed        = rsp_pushed_q;
	assign rsp.status        = rsp_status_q;

endmodule

// File: src/rbpa_mod_unit.sv
// Bit-serial remainder unit: round counter modulo the server count, one bit per cycle.
// Depends on rbpa_pkg.
module rbpa_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  rbpa_pkg::mod_req_t  req,
	output rbpa_pkg::mod_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [rbpa_pkg::STEP_W-1:0]         cnt_q;
	logic [rbpa_pkg::ROUND_W-1:0]        dvd_q;
	logic [rbpa_pkg::SCNT_W-1:0]         div_q;
	logic [rbpa_pkg::SCNT_W-1:0]         rem_q;
	logic [rbpa_pkg::SCNT_W:0]           trial;
	logic [rbpa_pkg::SCNT_W:0]           diff;

	assign trial = {rem_q, dvd_q[rbpa_pkg::ROUND_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= rbpa_pkg::STEP_W'(rbpa_pkg::ROUND_W);
				dvd_q  <= req.dividend;
				div_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				// restoring step: subtract when the trial remainder reaches the divisor
				if (trial >= {1'b0, div_q}) begin
					rem_q <= diff[rbpa_pkg::SCNT_W-1:0];
				end else begin
					rem_q <= trial[rbpa_pkg::SCNT_W-1:0];
				end
				dvd_q <= {dvd_q[rbpa_pkg::ROUND_W-2:0], 1'b0};
				cnt_q <= cnt_q - rbpa_pkg::STEP_W'(1);
				if (cnt_q == rbpa_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[rbpa_pkg::SRV_W-1:0];

endmodule

// File: src/rbpa_free_fifo.sv
// Free block FIFO: a queue memory of block indexes with head, tail and fill count.
// Depends on rbpa_pkg.
module rbpa_free_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rbpa_pkg::fifo_ctl_t               ctl,
	output rbpa_pkg::fifo_stat_t              stat,
	output logic [rbpa_pkg::IDX_W-1:0]        rd_idx
);

	logic [rbpa_pkg::IDX_W-1:0]  mem [rbpa_pkg::POOL_DEPTH];
	logic [rbpa_pkg::IDX_W-1:0]  head_q;
	logic [rbpa_pkg::IDX_W-1:0]  tail_q;
	logic [rbpa_pkg::FILL_W-1:0] fill_q;
	logic [rbpa_pkg::IDX_W-1:0]  rd_q;
	logic                        do_push;
	logic                        do_pop;

	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == rbpa_pkg::FILL_W'(rbpa_pkg::POOL_DEPTH));
	// drop a push into a full queue
	assign do_push    = ctl.push && !stat.full;
	assign do_pop     = ctl.pop && !stat.empty;
	assign rd_idx     = rd_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= ctl.push_idx;
		end
		if (do_pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == rbpa_pkg::IDX_W'(rbpa_pkg::POOL_DEPTH - 1)) ? '0
					: tail_q + rbpa_pkg::IDX_W'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == rbpa_pkg::IDX_W'(rbpa_pkg::POOL_DEPTH - 1)) ? '0
					: head_q + rbpa_pkg::IDX_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + rbpa_pkg::FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - rbpa_pkg::FILL_W'(1);
			end
		end
	end

endmodule

// File: src/rbpa_mark_mem.sv
// Allocation mark memory, one bit per block, with a clearing sweep after reset.
// Depends on rbpa_pkg.
module rbpa_mark_mem (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rbpa_pkg::mark_req_t  req,
	output logic                 rd_bit,
	output logic                 busy
);

	logic                       mem [rbpa_pkg::POOL_DEPTH];
	logic [rbpa_pkg::IDX_W-1:0] clr_q;
	logic                       busy_q;
	logic                       rd_q;

	assign busy   = busy_q;
	assign rd_bit = rd_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (req.we) begin
			mem[req.addr] <= req.wbit;
		end
		if (req.rd) begin
			rd_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == rbpa_pkg::IDX_W'(rbpa_pkg::POOL_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + rbpa_pkg::IDX_W'(1);
			end
		end
	end

endmodule
